// ----- sv/tea_pkg.sv -----
// shared constants and types for the taxon evidence accumulator
`timescale 1ns / 1ps
package tea_pkg;
  localparam int NUM_TAXA_DEF = 4096;
  localparam int MAX_SKETCH_BITS_DEF = 1024;
  localparam int FRACTION_BITS_DEF = 20;
  localparam int CFG_W = 11;
  localparam int CNT_W = 11;
  localparam int TAXON_W = 12;
  localparam logic [CFG_W-1:0] SKETCH_BITS_RESET = 11'd1024;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // one queued beat from front to back
  typedef struct packed {
    action_t     act;
    logic [TAXON_W-1:0] taxon;
    logic [31:0] hit_wt;
    logic [31:0] score_wt;
    logic [20:0] strength;
    logic        mark_u;
    logic [31:0] ubucket;
    logic        mark_b;
    logic [31:0] bbucket;
    logic        uread;
    logic        valid_taxon;
  } cmd_t;
endpackage

// ----- sv/taxon_evidence_accumulator.sv -----
// top level of the taxon evidence accumulator
`timescale 1ns / 1ps
// usage
// - input channel: drive the item fields with start high; a beat is taken at
//   a rising edge with start high and busy low
// - busy is high while the two-entry queue is full or the clearing pass runs
// - configuration: sketch_bits_we with sketch_bits_wdata, only while idle
// - add and read-support items give no result; in the back end they pass
//   through entry read, multiply and write back, where the queue pops
// - a query gives one result marked by done for one cycle; done is
//   registered from the output state that follows the popcount walk;
//   the sketch popcount walks one 64-bit word a cycle
// - the receiver cannot stall: results must be taken when done is high
// - reset: a clearing pass over NUM_TAXA * ceil(MAX_SKETCH_BITS / 64) sketch
//   words (65536 at default size) zeroes the table and sketches; busy stays
//   high during it; sketch_bits returns to 1024
module taxon_evidence_accumulator import tea_pkg::*; #(
  parameter int NUM_TAXA = NUM_TAXA_DEF,
  parameter int MAX_SKETCH_BITS = MAX_SKETCH_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] action,
  input  logic [TAXON_W-1:0] taxon,
  input  logic [31:0] hit_wt,
  input  logic [31:0] score_wt,
  input  logic [20:0] uniq_strength,
  input  logic local_unique_edge,
  input  logic [31:0] uniq_bucket,
  input  logic [31:0] brd_bucket,
  input  logic unique_read,
  input  logic sketch_bits_we,
  input  logic [CFG_W-1:0] sketch_bits_wdata,
  output logic done,
  output logic [63:0] total_score,
  output logic [63:0] total_hits,
  output logic [63:0] total_unique_hits,
  output logic [63:0] total_unique_score,
  output logic [31:0] read_hit_count,
  output logic [31:0] unique_read_count,
  output logic [CNT_W-1:0] unique_bits_set,
  output logic [CNT_W-1:0] breadth_bits_set
);
  logic [CFG_W-1:0] sketch_bits, clamped, words;
  logic accept, empty, full, pop, clearing;
  cmd_t head;

  // configuration register and words in use
  always_ff @(posedge clk) begin
    if (rst) sketch_bits <= SKETCH_BITS_RESET;
    else if (sketch_bits_we) sketch_bits <= sketch_bits_wdata;
  end
  assign clamped = (32'(sketch_bits) > 32'(MAX_SKETCH_BITS)) ?
                   CFG_W'(MAX_SKETCH_BITS) : sketch_bits;
  assign words = CFG_W'((12'(clamped) + 12'd63) >> 6);

  assign busy = full || clearing;
  assign accept = start && !busy;

  tea_front #(.NUM_TAXA(NUM_TAXA), .FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk, .rst, .accept, .action, .taxon, .hit_wt, .score_wt,
    .uniq_strength, .local_unique_edge, .uniq_bucket, .brd_bucket,
    .unique_read, .words, .pop, .empty, .full, .head
  );

  tea_back #(.NUM_TAXA(NUM_TAXA), .MAX_SKETCH_BITS(MAX_SKETCH_BITS),
             .FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk, .rst, .empty, .head, .words, .pop, .clearing, .done,
    .total_score, .total_hits, .total_unique_hits, .total_unique_score,
    .read_hit_count, .unique_read_count, .unique_bits_set, .breadth_bits_set
  );
endmodule

// ----- sv/tea_front.sv -----
// front end: accepts items, clamps strength, checks buckets, feeds a short queue
`timescale 1ns / 1ps
module tea_front import tea_pkg::*; #(
  parameter int NUM_TAXA = NUM_TAXA_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  logic [1:0] action,
  input  logic [TAXON_W-1:0] taxon,
  input  logic [31:0] hit_wt,
  input  logic [31:0] score_wt,
  input  logic [20:0] uniq_strength,
  input  logic local_unique_edge,
  input  logic [31:0] uniq_bucket,
  input  logic [31:0] brd_bucket,
  input  logic unique_read,
  input  logic [CFG_W-1:0] words,
  input  logic pop,
  output logic empty,
  output logic full,
  output cmd_t head
);
  localparam int DEPTH = 2;
  localparam logic [20:0] ONE = 21'(64'd1 << FRACTION_BITS);
  cmd_t q [DEPTH];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  cmd_t c;

  // classify the incoming beat
  always_comb begin
    c = '0;
    c.act = action_t'(action);
    c.taxon = taxon;
    c.hit_wt = hit_wt;
    c.score_wt = score_wt;
    c.strength = (uniq_strength > ONE) ? ONE : uniq_strength;
    c.ubucket = uniq_bucket;
    c.bbucket = brd_bucket;
    c.uread = unique_read;
    c.valid_taxon = (32'(taxon) < 32'(NUM_TAXA));
    c.mark_u = local_unique_edge && (words != '0) && (uniq_bucket != '1)
               && ((uniq_bucket >> 6) < 32'(words));
    c.mark_b = local_unique_edge && (words != '0) && (brd_bucket != '1)
               && ((brd_bucket >> 6) < 32'(words));
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (accept) q[wr_ptr] <= c;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (accept) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(accept) - 2'(pop);
    end
  end

  assign empty = (count == '0);
  assign full = (count == 2'(DEPTH));
  assign head = q[rd_ptr];
endmodule

// ----- sv/tea_back.sv -----
// back end: clearing pass, table read-modify-write, sketch popcount for queries
`timescale 1ns / 1ps
module tea_back import tea_pkg::*; #(
  parameter int NUM_TAXA = NUM_TAXA_DEF,
  parameter int MAX_SKETCH_BITS = MAX_SKETCH_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic empty,
  input  cmd_t head,
  input  logic [CFG_W-1:0] words,
  output logic pop,
  output logic clearing,
  output logic done,
  output logic [63:0] total_score,
  output logic [63:0] total_hits,
  output logic [63:0] total_unique_hits,
  output logic [63:0] total_unique_score,
  output logic [31:0] read_hit_count,
  output logic [31:0] unique_read_count,
  output logic [CNT_W-1:0] unique_bits_set,
  output logic [CNT_W-1:0] breadth_bits_set
);
  localparam int WPS = (MAX_SKETCH_BITS + 63) / 64;
  localparam int WW = (WPS > 1) ? $clog2(WPS) : 1;
  localparam int TW = (NUM_TAXA > 1) ? $clog2(NUM_TAXA) : 1;
  localparam int SW = TW + WW;
  localparam int SDEPTH = NUM_TAXA * WPS;
  localparam int PW = 32 + 21;
  localparam logic [PW-1:0] HALF = PW'(64'd1 << (FRACTION_BITS - 1));
  localparam int EW = 64 * 4 + 64;

  typedef enum logic [7:0] {
    S_CLR   = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_RD    = 8'b00000100,
    S_MUL   = 8'b00001000,
    S_WR    = 8'b00010000,
    S_CNT   = 8'b00100000,
    S_CNTW  = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t state, state_next;
  logic [63:0] ent_mem [NUM_TAXA][5];
  logic [63:0] usk_mem [SDEPTH];
  logic [63:0] bsk_mem [SDEPTH];
  logic [SW:0] clr_idx;
  cmd_t cur;
  logic [TW-1:0] tix;
  logic [EW-1:0] ent_rd;
  logic [63:0] usk_rd, bsk_rd;
  logic [PW-1:0] prod_h, prod_s;
  logic [WW:0] widx;
  logic [CNT_W-1:0] ucnt, bcnt;
  logic [SW-1:0] uaddr, baddr;
  logic [63:0] e_score, e_hits, e_uh, e_us;
  logic [31:0] e_rh, e_ur;

  assign tix = cur.taxon[TW-1:0];
  assign e_score = ent_rd[63:0];
  assign e_hits = ent_rd[127:64];
  assign e_uh = ent_rd[191:128];
  assign e_us = ent_rd[255:192];
  assign e_rh = ent_rd[287:256];
  assign e_ur = ent_rd[319:288];

  // sketch word addresses for the current step
  always_comb begin
    uaddr = '0;
    baddr = '0;
    if (state == S_CLR) begin
      uaddr = clr_idx[SW-1:0];
      baddr = clr_idx[SW-1:0];
    end else if (state == S_CNT || state == S_CNTW) begin
      uaddr = SW'({tix, {WW{1'b0}}}) + SW'(widx);
      baddr = SW'({tix, {WW{1'b0}}}) + SW'(widx);
    end else begin
      uaddr = SW'({tix, {WW{1'b0}}}) + SW'(cur.ubucket[WW+5:6]);
      baddr = SW'({tix, {WW{1'b0}}}) + SW'(cur.bbucket[WW+5:6]);
    end
  end

  // control sequence
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR:  if (clr_idx == (SW+1)'(SDEPTH - 1)) state_next = S_IDLE;
      S_IDLE: if (!empty) state_next = S_RD;
      S_RD:   begin
        if (head.act == ACT_NONE ||
            (!head.valid_taxon && head.act != ACT_QUERY)) state_next = S_IDLE;
        else if (head.act == ACT_QUERY)
          state_next = head.valid_taxon ? S_CNT : S_OUT;
        else state_next = S_MUL;
      end
      S_MUL:  state_next = S_WR;
      S_WR:   state_next = S_IDLE;
      S_CNT:  state_next = S_CNTW;
      S_CNTW: state_next = (widx >= (WW+1)'(words)) ? S_OUT : S_CNTW;
      S_OUT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign cur = head;
  assign pop = (state == S_WR) || (state == S_OUT) || (state == S_RD && (head.act == ACT_NONE
               || (!head.valid_taxon && head.act != ACT_QUERY)));
  assign clearing = (state == S_CLR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_idx <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == S_OUT);
      if (state == S_CLR) clr_idx <= clr_idx + (SW+1)'(1);
    end
  end

  // entry and sketch memories
  always_ff @(posedge clk) begin
    ent_rd <= {ent_mem[tix][4], ent_mem[tix][3], ent_mem[tix][2], ent_mem[tix][1],
               ent_mem[tix][0]};
    usk_rd <= usk_mem[uaddr];
    bsk_rd <= bsk_mem[baddr];
    if (state == S_CLR) begin
      usk_mem[clr_idx[SW-1:0]] <= '0;
      bsk_mem[clr_idx[SW-1:0]] <= '0;
      if (clr_idx < (SW+1)'(NUM_TAXA)) begin
        ent_mem[clr_idx[TW-1:0]][0] <= '0;
        ent_mem[clr_idx[TW-1:0]][1] <= '0;
        ent_mem[clr_idx[TW-1:0]][2] <= '0;
        ent_mem[clr_idx[TW-1:0]][3] <= '0;
        ent_mem[clr_idx[TW-1:0]][4] <= '0;
      end
    end else if (state == S_MUL && cur.act == ACT_ADD && cur.mark_u) begin
      usk_mem[uaddr] <= usk_rd | (64'd1 << cur.ubucket[5:0]);
    end else if (state == S_WR) begin
      if (cur.act == ACT_ADD) begin
        ent_mem[tix][0] <= e_score + 64'(cur.score_wt);
        ent_mem[tix][1] <= e_hits + 64'(cur.hit_wt);
        ent_mem[tix][2] <= e_uh + 64'((prod_h + HALF) >> FRACTION_BITS);
        ent_mem[tix][3] <= e_us + 64'((prod_s + HALF) >> FRACTION_BITS);
        if (cur.mark_b) bsk_mem[baddr] <= bsk_rd | (64'd1 << cur.bbucket[5:0]);
      end else begin
        ent_mem[tix][4] <= {e_ur + 32'(cur.uread), e_rh + 32'd1};
      end
    end
  end

  // weight products, registered before the add
  always_ff @(posedge clk) begin
    prod_h <= PW'(cur.hit_wt) * PW'(cur.strength);
    prod_s <= PW'(cur.score_wt) * PW'(cur.strength);
  end

  // popcount walk over the words in use, one word a cycle
  always_ff @(posedge clk) begin
    if (state == S_CNT) begin
      widx <= (WW+1)'(1);
      ucnt <= '0;
      bcnt <= '0;
    end else if (state == S_CNTW) begin
      widx <= widx + (WW+1)'(1);
      if (widx <= (WW+1)'(words) && widx != '0) begin
        ucnt <= ucnt + CNT_W'($countones(usk_rd));
        bcnt <= bcnt + CNT_W'($countones(bsk_rd));
      end
    end else if (state == S_IDLE) begin
      widx <= '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_OUT) begin
      if (cur.valid_taxon) begin
        total_score <= e_score;
        total_hits <= e_hits;
        total_unique_hits <= e_uh;
        total_unique_score <= e_us;
        read_hit_count <= e_rh;
        unique_read_count <= e_ur;
        unique_bits_set <= ucnt;
        breadth_bits_set <= bcnt;
      end else begin
        total_score <= '0;
        total_hits <= '0;
        total_unique_hits <= '0;
        total_unique_score <= '0;
        read_hit_count <= '0;
        unique_read_count <= '0;
        unique_bits_set <= '0;
        breadth_bits_set <= '0;
      end
    end
  end
endmodule

// ----- sv/tea_checker.sv -----
// port-level checks for the taxon evidence accumulator
`timescale 1ns / 1ps
module tea_checker import tea_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic [CNT_W-1:0] unique_bits_set,
  input logic [CNT_W-1:0] breadth_bits_set
);
  // a result is one cycle wide
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");
  // busy is high just after reset for the clearing pass
  a_busy_reset: assert property (@(posedge clk)
    $past(rst) |-> busy) else $error("not busy after reset");
  // popcounts stay within the sketch size
  a_pop_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (unique_bits_set <= 11'd1024 && breadth_bits_set <= 11'd1024))
    else $error("popcount out of range");
endmodule

bind taxon_evidence_accumulator tea_checker u_chk (
  .clk, .rst, .start, .busy, .done, .unique_bits_set, .breadth_bits_set
);

// ----- tb/taxon_evidence_accumulator_check.sv -----
// checker for the taxon evidence accumulator: predicts query results and compares them
`timescale 1ns / 1ps
module taxon_evidence_accumulator_check import tea_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  logic [1:0] action,
  input  logic [TAXON_W-1:0] taxon,
  input  logic [31:0] hit_wt,
  input  logic [31:0] score_wt,
  input  logic [20:0] uniq_strength,
  input  logic local_unique_edge,
  input  logic [31:0] uniq_bucket,
  input  logic [31:0] brd_bucket,
  input  logic unique_read,
  input  logic sketch_bits_we,
  input  logic [CFG_W-1:0] sketch_bits_wdata,
  input  logic done,
  input  logic [63:0] total_score,
  input  logic [63:0] total_hits,
  input  logic [63:0] total_unique_hits,
  input  logic [63:0] total_unique_score,
  input  logic [31:0] read_hit_count,
  input  logic [31:0] unique_read_count,
  input  logic [CNT_W-1:0] unique_bits_set,
  input  logic [CNT_W-1:0] breadth_bits_set,
  output int fail_count,
  output int pending
);
  localparam int WORDS = (MAX_SKETCH_BITS_DEF + 63) / 64;
  localparam logic [31:0] NO_BUCKET = 32'hffff_ffff;
  localparam logic [63:0] ONE = 64'd1 << FRACTION_BITS_DEF;

  typedef struct {
    logic [63:0] score;
    logic [63:0] hits;
    logic [63:0] uhits;
    logic [63:0] uscore;
    logic [31:0] reads;
    logic [31:0] ureads;
    logic [CNT_W-1:0] ubits;
    logic [CNT_W-1:0] bbits;
  } evidence_t;

  logic [63:0] score_tbl [NUM_TAXA_DEF];
  logic [63:0] hits_tbl [NUM_TAXA_DEF];
  logic [63:0] uhits_tbl [NUM_TAXA_DEF];
  logic [63:0] uscore_tbl [NUM_TAXA_DEF];
  logic [31:0] reads_tbl [NUM_TAXA_DEF];
  logic [31:0] ureads_tbl [NUM_TAXA_DEF];
  logic [63:0] usketch [NUM_TAXA_DEF * WORDS];
  logic [63:0] bsketch [NUM_TAXA_DEF * WORDS];
  logic [CFG_W-1:0] sketch_cfg;
  evidence_t query_result_q [$];
  int mismatches = 0;
  int strays = 0;

  assign fail_count = mismatches + strays;
  assign pending = query_result_q.size();

  function automatic int words_in_use();
    int bits;
    bits = (sketch_cfg > MAX_SKETCH_BITS_DEF) ? MAX_SKETCH_BITS_DEF : int'(sketch_cfg);
    return (bits + 63) >> 6;
  endfunction

  function automatic logic [63:0] scale_round(logic [63:0] w, logic [63:0] s);
    return (w * s + (64'd1 << (FRACTION_BITS_DEF - 1))) >> FRACTION_BITS_DEF;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch %s: expected %h actual %h", $realtime, name, exp_v, act_v);
    end
  endtask

  // apply one accepted beat to the shadow table
  task automatic apply_item();
    int t, w, idx;
    logic [63:0] s;
    evidence_t r;
    t = int'(taxon);
    w = words_in_use();
    unique case (action)
      ACT_ADD: begin
        s = (uniq_strength > ONE) ? ONE : 64'(uniq_strength);
        score_tbl[t] += 64'(score_wt);
        hits_tbl[t] += 64'(hit_wt);
        if (s != 0) begin
          uhits_tbl[t] += scale_round(64'(hit_wt), s);
          uscore_tbl[t] += scale_round(64'(score_wt), s);
        end
        if (local_unique_edge && w > 0) begin
          idx = int'(uniq_bucket >> 6);
          if (uniq_bucket != NO_BUCKET && (uniq_bucket >> 6) < w)
            usketch[t * WORDS + idx][uniq_bucket[5:0]] = 1'b1;
          idx = int'(brd_bucket >> 6);
          if (brd_bucket != NO_BUCKET && (brd_bucket >> 6) < w)
            bsketch[t * WORDS + idx][brd_bucket[5:0]] = 1'b1;
        end
      end
      ACT_READ: begin
        reads_tbl[t] += 32'd1;
        if (unique_read) ureads_tbl[t] += 32'd1;
      end
      ACT_QUERY: begin
        r.score = score_tbl[t];
        r.hits = hits_tbl[t];
        r.uhits = uhits_tbl[t];
        r.uscore = uscore_tbl[t];
        r.reads = reads_tbl[t];
        r.ureads = ureads_tbl[t];
        r.ubits = '0;
        r.bbits = '0;
        for (int i = 0; i < w; i++) begin
          r.ubits += CNT_W'($countones(usketch[t * WORDS + i]));
          r.bbits += CNT_W'($countones(bsketch[t * WORDS + i]));
        end
        query_result_q = {query_result_q, r};
      end
      default: ;
    endcase
  endtask

  // watch config, input and result beats
  always @(posedge clk) begin
    evidence_t e;
    if (rst) begin
      for (int i = 0; i < NUM_TAXA_DEF; i++) begin
        score_tbl[i] = '0;
        hits_tbl[i] = '0;
        uhits_tbl[i] = '0;
        uscore_tbl[i] = '0;
        reads_tbl[i] = '0;
        ureads_tbl[i] = '0;
      end
      for (int i = 0; i < NUM_TAXA_DEF * WORDS; i++) begin
        usketch[i] = '0;
        bsketch[i] = '0;
      end
      sketch_cfg = SKETCH_BITS_RESET;
    end else begin
      if (sketch_bits_we) sketch_cfg = sketch_bits_wdata;
      if (done) begin
        if (query_result_q.size() == 0) begin
          strays++;
          $display("%0t result beat with nothing expected", $realtime);
        end else begin
          e = query_result_q.pop_front();
          check_field("total_score", e.score, total_score);
          check_field("total_hits", e.hits, total_hits);
          check_field("total_unique_hits", e.uhits, total_unique_hits);
          check_field("total_unique_score", e.uscore, total_unique_score);
          check_field("read_hit_count", 64'(e.reads), 64'(read_hit_count));
          check_field("unique_read_count", 64'(e.ureads), 64'(unique_read_count));
          check_field("unique_bits_set", 64'(e.ubits), 64'(unique_bits_set));
          check_field("breadth_bits_set", 64'(e.bbits), 64'(breadth_bits_set));
        end
      end
      if (start && !busy) apply_item();
    end
  end
endmodule

// ----- tb/taxon_evidence_accumulator_test.sv -----
// stimulus and verdict for the taxon evidence accumulator
`timescale 1ns / 1ps
module taxon_evidence_accumulator_test;
  import tea_pkg::*;

  localparam int WATCHDOG_LIMIT = 500000;
  localparam int SETTLE = 64;
  localparam logic [20:0] ONE_Q = 21'h10_0000;

  typedef struct {
    logic [1:0] act;
    logic [TAXON_W-1:0] taxon;
    logic [31:0] hit;
    logic [31:0] score;
    logic [20:0] strength;
    logic edge_flag;
    logic [31:0] ubucket;
    logic [31:0] bbucket;
    logic uread;
  } item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] action = '0;
  logic [TAXON_W-1:0] taxon = '0;
  logic [31:0] hit_wt = '0;
  logic [31:0] score_wt = '0;
  logic [20:0] uniq_strength = '0;
  logic local_unique_edge = 1'b0;
  logic [31:0] uniq_bucket = '0;
  logic [31:0] brd_bucket = '0;
  logic unique_read = 1'b0;
  logic sketch_bits_we = 1'b0;
  logic [CFG_W-1:0] sketch_bits_wdata = '0;
  logic done;
  logic [63:0] total_score, total_hits, total_unique_hits, total_unique_score;
  logic [31:0] read_hit_count, unique_read_count;
  logic [CNT_W-1:0] unique_bits_set, breadth_bits_set;
  int fail_count, pending;
  int idle_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  taxon_evidence_accumulator dut (.*);
  taxon_evidence_accumulator_check checker_i (.*);

  // watchdog on cycles with no beat in either direction
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("taxon_evidence_accumulator regression: fail");
      $finish;
    end
  end

  function automatic item_t mk(logic [1:0] a, logic [TAXON_W-1:0] t, logic [31:0] h,
                               logic [31:0] s, logic [20:0] st, logic e,
                               logic [31:0] ub, logic [31:0] bb, logic ur);
    item_t it;
    it.act = a; it.taxon = t; it.hit = h; it.score = s; it.strength = st;
    it.edge_flag = e; it.ubucket = ub; it.bbucket = bb; it.uread = ur;
    return it;
  endfunction

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0020_0000);
      2: return 32'hffff_ffff;
      default: return $urandom & 32'h00ff_ffff;
    endcase
  endfunction

  function automatic logic [31:0] rand_bucket();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 32'hffff_ffff;
    if (r < 75) return $urandom_range(0, 1100);
    return $urandom;
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int r;
    r = $urandom_range(0, 99);
    it.act = (r < 45) ? ACT_ADD : (r < 70) ? ACT_READ : (r < 95) ? ACT_QUERY : ACT_NONE;
    r = $urandom_range(0, 9);
    it.taxon = (r < 8) ? TAXON_W'($urandom_range(0, 7)) : (r == 8) ? '1 : TAXON_W'($urandom);
    it.hit = rand_weight();
    it.score = rand_weight();
    case ($urandom_range(0, 4))
      0: it.strength = '0;
      1: it.strength = ONE_Q;
      2: it.strength = 21'($urandom_range(ONE_Q, 21'h1f_ffff));
      default: it.strength = 21'($urandom_range(0, ONE_Q));
    endcase
    it.edge_flag = $urandom_range(0, 3) != 0;
    it.ubucket = rand_bucket();
    it.bbucket = rand_bucket();
    it.uread = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // drive one beat after a random gap and hold it until taken
  task automatic send(item_t it);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    action <= it.act;
    taxon <= it.taxon;
    hit_wt <= it.hit;
    score_wt <= it.score;
    uniq_strength <= it.strength;
    local_unique_edge <= it.edge_flag;
    uniq_bucket <= it.ubucket;
    brd_bucket <= it.bbucket;
    unique_read <= it.uread;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_sketch_bits(logic [CFG_W-1:0] v);
    drain();
    sketch_bits_we <= 1'b1;
    sketch_bits_wdata <= v;
    @(posedge clk);
    sketch_bits_we <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] phase_cfg [8];
    phase_cfg = '{11'd1024, 11'd0, 11'd1, 11'd64, 11'd65, 11'd2047, 11'd1023, 11'd0};
    phase_cfg[7] = CFG_W'($urandom);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    // directed: extremes, rounding, bucket edges, unused action
    send(mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_ADD, 0, '1, '1, ONE_Q, 1, 0, 1023, 0));
    send(mk(ACT_ADD, 0, '1, '1, 21'h1f_ffff, 1, 63, 64, 0));
    send(mk(ACT_ADD, 0, 32'h1234_5678, 32'h0000_0001, 0, 1, '1, '1, 0));
    send(mk(ACT_ADD, 0, 32'h0008_0000, 32'h0007_ffff, 21'd1, 1, 1024, 32'h8000_0000, 0));
    send(mk(ACT_ADD, 0, 32'h0010_0000, 32'h0030_0000, 21'h08_0000, 0, 5, 6, 0));
    send(mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 1));
    send(mk(ACT_NONE, 0, '1, '1, ONE_Q, 1, 7, 7, 1));
    send(mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_ADD, '1, '1, 0, 21'h1f_ffff, 1, 32'h0000_03ff, 32'hffff_fffe, 1));
    send(mk(ACT_READ, '1, 0, 0, 0, 0, 0, 0, 1));
    send(mk(ACT_QUERY, '1, 0, 0, 0, 0, 0, 0, 0));
    send(mk(ACT_QUERY, 12'd100, '1, '1, '1, 1, '1, '1, 1));

    // random phases across sketch sizes
    for (int p = 0; p < 8; p++) begin
      write_sketch_bits(phase_cfg[p]);
      if (p == 5) begin
        send(mk(ACT_ADD, 1, 1, 1, ONE_Q, 1, 1023, 1024, 0));
        send(mk(ACT_QUERY, 1, 0, 0, 0, 0, 0, 0, 0));
      end
      repeat (50) send(rand_item());
    end

    drain();
    if (fail_count == 0) begin
      $display("taxon_evidence_accumulator regression: pass");
    end else begin
      $display("taxon_evidence_accumulator regression: fail");
    end
    $finish;
  end
endmodule

// ----- files.f -----
sv/tea_pkg.sv
sv/tea_front.sv
sv/tea_back.sv
sv/taxon_evidence_accumulator.sv
sv/tea_checker.sv
tb/taxon_evidence_accumulator_check.sv
tb/taxon_evidence_accumulator_test.sv
